@@ design/lbme_pkg.sv @@
// Package: shared types and constants for the loss burst model estimator.
package lbme_pkg;

  localparam logic [7:0] GAP_DEFAULT = 8'd16;
  localparam int unsigned FRAC_W = 16;
  localparam int unsigned OUT_W = 32;

  typedef struct packed {
    logic [FRAC_W-1:0] good_to_bad_prob;
    logic [FRAC_W-1:0] bad_to_good_prob;
    logic [FRAC_W-1:0] good_receive_prob;
    logic [FRAC_W-1:0] bad_receive_prob;
    logic [3:0]        undefined_mask;
    logic [OUT_W-1:0]  burst_total;
    logic [OUT_W-1:0]  trace_length;
    logic              count_overflow;
  } result_t;

  typedef struct packed {
    logic sample_received;
    logic last_sample;
  } sample_t;

  // controller -> datapath
  typedef struct packed {
    logic step;      // update counters with the accepted beat
    logic finish;    // close the trace (final burst fixup)
    logic div_start; // load divider with fraction selected by div_sel
    logic [1:0] div_sel;
    logic div_step;  // one quotient bit
    logic div_store; // store finished quotient
    logic clear;     // clear trace state
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic div_done;
  } dp_sts_t;

endpackage

@@ design/lbme_if.sv @@
// Interfaces: valid/ready channels for samples and results.
interface lbme_sample_if;
  import lbme_pkg::*;
  logic    valid;
  logic    ready;
  sample_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface lbme_result_if;
  import lbme_pkg::*;
  logic    valid;
  logic    ready;
  result_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ design/lbme_ctrl.sv @@
// Controller: sequences per-sample updates, end-of-trace divisions, result beat.
module lbme_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_last,
  output logic               out_valid,
  input  logic               out_ready,
  output lbme_pkg::dp_cmd_t  cmd,
  input  lbme_pkg::dp_sts_t  sts
);
  import lbme_pkg::*;

  typedef enum logic [4:0] {
    ST_RUN    = 5'b00001,
    ST_FINISH = 5'b00010,
    ST_LOAD   = 5'b00100,
    ST_DIV    = 5'b01000,
    ST_OUT    = 5'b10000
  } state_t;

  state_t state_r, state_nxt;
  logic [1:0] sel_r, sel_nxt;

  assign in_ready  = (state_r == ST_RUN);
  assign out_valid = (state_r == ST_OUT);

  always_comb begin
    state_nxt = state_r;
    sel_nxt = sel_r;
    cmd = '0;
    cmd.div_sel = sel_r;
    case (state_r)
      ST_RUN: begin
        if (in_valid) begin
          cmd.step = 1'b1;
          if (in_last) state_nxt = ST_FINISH;
        end
      end
      ST_FINISH: begin
        cmd.finish = 1'b1;
        sel_nxt = 2'd0;
        state_nxt = ST_LOAD;
      end
      ST_LOAD: begin
        cmd.div_start = 1'b1;
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        if (sts.div_done) begin
          cmd.div_store = 1'b1;
          if (sel_r == 2'd3) begin
            state_nxt = ST_OUT;
          end else begin
            sel_nxt = sel_r + 2'd1;
            state_nxt = ST_LOAD;
          end
        end else begin
          cmd.div_step = 1'b1;
        end
      end
      ST_OUT: begin
        if (out_ready) begin
          cmd.clear = 1'b1;
          state_nxt = ST_RUN;
        end
      end
      default: state_nxt = ST_RUN;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_RUN;
      sel_r <= 2'd0;
    end else begin
      state_r <= state_nxt;
      sel_r <= sel_nxt;
    end
  end
endmodule

@@ design/lbme_dp.sv @@
// Datapath: burst tracking counters, shared restoring divider, result register.
module lbme_dp #(
  parameter int unsigned COUNT_WIDTH = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic [7:0]         gap_minimum,
  input  lbme_pkg::sample_t  sample,
  input  lbme_pkg::dp_cmd_t  cmd,
  output lbme_pkg::dp_sts_t  sts,
  output lbme_pkg::result_t  result
);
  import lbme_pkg::*;

  localparam int unsigned CW = COUNT_WIDTH;
  localparam int unsigned QW = FRAC_W;
  localparam int unsigned CNTW = $clog2(QW + 1);
  localparam logic [CW-1:0] CMAX = {CW{1'b1}};
  localparam logic [CW-1:0] ONE = {{(CW-1){1'b0}}, 1'b1};

  logic [CW-1:0] pos_r, lost_r, ppos_r, lbp_r, bstart_r, bend_r, lbb_r, ltb_r;
  logic [CW-1:0] blen_r, blost_r, bcnt_r;
  logic pvalid_r, bopen_r, origin_r, ovf_r, ends_bad_r;

  logic [CW-1:0] gap;
  assign gap = CW'(((gap_minimum == 8'd0) ? GAP_DEFAULT : gap_minimum));

  // per-sample combinational view
  logic linked;
  assign linked = pvalid_r && ((pos_r - ppos_r - ONE) < gap);

  // end-of-trace fixup
  logic [CW-1:0] last_idx;
  logic ext;
  assign last_idx = (pos_r != '0) ? pos_r - ONE : '0;
  assign ext = bopen_r && ((last_idx - bend_r) < gap);

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.clear) begin
      pos_r <= '0; lost_r <= '0; ppos_r <= '0; lbp_r <= '0;
      bstart_r <= '0; bend_r <= '0; lbb_r <= '0; ltb_r <= '0;
      blen_r <= '0; blost_r <= '0; bcnt_r <= '0;
      pvalid_r <= 1'b0; bopen_r <= 1'b0;
      origin_r <= 1'b0; ovf_r <= 1'b0; ends_bad_r <= 1'b0;
    end else if (cmd.step) begin
      if (pos_r == CMAX) begin
        ovf_r <= 1'b1;
      end else begin
        pos_r <= pos_r + ONE;
        if (!sample.sample_received) begin
          if (linked) begin
            if (!bopen_r) begin
              bopen_r <= 1'b1;
              bstart_r <= ppos_r;
              lbb_r <= lbp_r;
              if (bcnt_r == '0 && ppos_r == '0) origin_r <= 1'b1;
            end
            bend_r <= pos_r;
            ltb_r <= lost_r + ONE;
          end else if (bopen_r) begin
            blen_r <= blen_r + (bend_r - bstart_r + ONE);
            blost_r <= blost_r + (ltb_r - lbb_r);
            bcnt_r <= bcnt_r + ONE;
            bopen_r <= 1'b0;
          end
          ppos_r <= pos_r;
          lbp_r <= lost_r;
          pvalid_r <= 1'b1;
          lost_r <= lost_r + ONE;
        end
      end
    end else if (cmd.finish) begin
      if (bopen_r) begin
        blen_r <= blen_r + ((ext ? last_idx : bend_r) - bstart_r + ONE);
        blost_r <= blost_r + ((ext ? lost_r : ltb_r) - lbb_r);
        bcnt_r <= bcnt_r + ONE;
        bopen_r <= 1'b0;
        ends_bad_r <= ext || (bend_r == last_idx);
      end
    end
  end

  // fraction operands
  logic [CW-1:0] gb, bg, good_len, good_lost, p_den;
  assign gb = bcnt_r - ((bcnt_r != '0 && origin_r) ? ONE : '0);
  assign bg = bcnt_r - ((bcnt_r != '0 && ends_bad_r) ? ONE : '0);
  assign good_len = pos_r - blen_r;
  assign good_lost = lost_r - blost_r;
  assign p_den = good_len - ((!ends_bad_r && good_len != '0) ? ONE : '0);

  logic [CW-1:0] num, den;
  always_comb begin
    case (cmd.div_sel)
      2'd0: begin num = gb; den = p_den; end
      2'd1: begin num = bg; den = blen_r; end
      2'd2: begin num = good_len - good_lost; den = good_len; end
      default: begin num = blen_r - blost_r; den = blen_r; end
    endcase
  end

  // restoring divider: num < den so the remainder fits CW+1 bits
  logic [CW:0]     rem_r;
  logic [CW-1:0]   den_r;
  logic [QW-1:0]   quo_r;
  logic [CNTW-1:0] cnt_r;
  logic            sat_r, zero_r;
  logic [CW:0]     trial;
  assign trial = {rem_r[CW-1:0], 1'b0} - {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (cmd.div_start) begin
      rem_r <= {1'b0, num};
      den_r <= den;
      quo_r <= '0;
      zero_r <= (den == '0);
      sat_r <= (num >= den);
      cnt_r <= CNTW'(QW);
    end else if (cmd.div_step) begin
      if (!trial[CW]) begin
        rem_r <= trial;
        quo_r <= {quo_r[QW-2:0], 1'b1};
      end else begin
        rem_r <= {rem_r[CW-1:0], 1'b0};
        quo_r <= {quo_r[QW-2:0], 1'b0};
      end
      cnt_r <= cnt_r - CNTW'(1);
    end
  end

  assign sts.div_done = (cnt_r == '0) || zero_r || sat_r;

  logic [QW-1:0] qval;
  assign qval = zero_r ? '0 : (sat_r ? {QW{1'b1}} : quo_r);

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.clear) begin
      result.undefined_mask <= '0;
    end else if (cmd.div_store) begin
      case (cmd.div_sel)
        2'd0: result.good_to_bad_prob <= qval;
        2'd1: result.bad_to_good_prob <= qval;
        2'd2: result.good_receive_prob <= qval;
        default: result.bad_receive_prob <= qval;
      endcase
      result.undefined_mask[cmd.div_sel] <= zero_r;
    end
    if (cmd.finish) begin
      result.trace_length <= OUT_W'(pos_r);
      result.count_overflow <= ovf_r || ((CW > OUT_W) &&
        (({{OUT_W{1'b0}}, pos_r} >> OUT_W) != '0));
    end
    if (cmd.div_start && cmd.div_sel == 2'd0) begin
      result.burst_total <= OUT_W'(bcnt_r);
      if ((CW > OUT_W) && (({{OUT_W{1'b0}}, bcnt_r} >> OUT_W) != '0))
        result.count_overflow <= 1'b1;
    end
  end
endmodule

@@ design/loss_burst_model_estimator.sv @@
// Top level: Gilbert-Elliott loss model estimator over a streamed packet trace.
// Throughput: one sample beat per cycle while the trace runs.
// After the last sample: one fixup step, then four Q0.16 divisions, each a load, 16 quotient
//   bits and a store (ending early on a zero or saturating fraction), before out_valid rises.
// The shared bit-serial divider runs the four divisions one after another.
// Reset (rst_n low, synchronous) clears all trace state; gap_minimum returns to 16.
module loss_burst_model_estimator #(
  parameter int unsigned COUNT_WIDTH = 32
) (
  input  logic       clk,
  input  logic       rst_n,
  lbme_sample_if.sink   in_ch,
  lbme_result_if.source out_ch,
  input  logic       cfg_we,
  input  logic [7:0] cfg_wdata
);
  import lbme_pkg::*;

  // gap minimum register; zero maps to the default inside the datapath
  logic [7:0] gap_r;
  always_ff @(posedge clk) begin
    if (!rst_n) gap_r <= GAP_DEFAULT;
    else if (cfg_we) gap_r <= cfg_wdata;
  end

  dp_cmd_t cmd;
  dp_sts_t sts;

  // controller holds in_ready low from the last beat until the result is taken
  lbme_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .in_last   (in_ch.data.last_sample),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  lbme_dp #(.COUNT_WIDTH(COUNT_WIDTH)) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .gap_minimum (gap_r),
    .sample      (in_ch.data),
    .cmd         (cmd),
    .sts         (sts),
    .result      (out_ch.data)
  );
endmodule

@@ design/lbme_checker.sv @@
// Checker: port-level assertions for the estimator, bound to the top level.
module lbme_checker (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic in_last,
  input logic out_valid,
  input logic out_ready,
  input logic [3:0] out_mask,
  input logic [15:0] out_p
);
  // no new sample while a result is pending
  a_no_in_when_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready) else $error("input open during result");
  // last beat closes the input
  a_last_closes: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_last) |=> !in_ready) else $error("input open after last");
  // result taken reopens the input
  a_reopen: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready) |=> in_ready && !out_valid) else $error("no reopen");
  // undefined p reads zero
  a_p_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_mask[0]) |-> out_p == 16'd0) else $error("undefined p nonzero");
endmodule

bind loss_burst_model_estimator lbme_checker u_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .in_last   (in_ch.data.last_sample),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_mask  (out_ch.data.undefined_mask),
  .out_p     (out_ch.data.good_to_bad_prob)
);

@@ tb/tb_loss_burst_model_estimator.sv @@
// Testbench for loss_burst_model_estimator: directed and random traces against a predictor.
module tb_loss_burst_model_estimator;
  import lbme_pkg::*;

  localparam int unsigned LIMIT = 400000;   // cycles; slowest clean run is far below this
  localparam int unsigned DRAIN = 100;      // cycles; idle drain after every result is back
  localparam longint unsigned COUNT_FULL = 64'h0000_0000_FFFF_FFFF;
  localparam logic [3:0] UNDEF_P = 4'b0001;
  localparam logic [3:0] UNDEF_R = 4'b0010;
  localparam logic [3:0] UNDEF_K = 4'b0100;
  localparam logic [3:0] UNDEF_H = 4'b1000;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       cfg_we = 1'b0;
  logic [7:0] cfg_wdata = 8'd0;

  lbme_sample_if in_ch ();
  lbme_result_if out_ch ();

  loss_burst_model_estimator dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch.sink),
    .out_ch    (out_ch.source),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Predictor state: a mirror of the block's trace counters.
  // ---------------------------------------------------------------------------
  logic [7:0]      gap_reg;
  longint unsigned pos_cnt, lost_cnt, prev_loss_pos, lost_before_prev;
  longint unsigned run_first, run_last, lost_before_run, lost_thru_run;
  longint unsigned bad_len_sum, bad_lost_total, burst_cnt;
  bit              prev_loss_seen, run_open, burst_at_origin, cnt_saturated;

  result_t results_due[$];   // expected end-of-trace results, oldest first
  int unsigned mismatches = 0;
  int unsigned cycles = 0;
  bit          calm = 1'b0;  // no idling on either side while set

  function automatic void clear_trace();
    pos_cnt = 0; lost_cnt = 0; prev_loss_pos = 0; lost_before_prev = 0;
    run_first = 0; run_last = 0; lost_before_run = 0; lost_thru_run = 0;
    bad_len_sum = 0; bad_lost_total = 0; burst_cnt = 0;
    prev_loss_seen = 0; run_open = 0; burst_at_origin = 0; cnt_saturated = 0;
  endfunction

  function automatic void close_run();
    bad_len_sum += run_last - run_first + 1;
    bad_lost_total += lost_thru_run - lost_before_run;
    burst_cnt++;
    run_open = 0;
  endfunction

  // Q0.16, saturating; zero denominator flags the field and yields 0
  function automatic logic [15:0] q16_frac(longint unsigned num, longint unsigned den,
                                           logic [3:0] flag, inout logic [3:0] mask);
    if (den == 0) begin
      mask |= flag;
      return 16'd0;
    end
    if (num >= den) return 16'hFFFF;
    return 16'((num << 16) / den);
  endfunction

  // One accepted beat; returns 1 and fills est when the trace closes.
  function automatic bit burst_model_step(bit rcv, bit last, output result_t est);
    longint unsigned g, t, n, last_idx, gb, bg, good_len, good_lost, p_den;
    bit linked, ends_bad;
    logic [3:0] mask;
    g = (gap_reg == 0) ? longint'(GAP_DEFAULT) : longint'(gap_reg);
    est = '0;
    if (pos_cnt >= COUNT_FULL) begin
      cnt_saturated = 1;
    end else begin
      t = pos_cnt;
      pos_cnt++;
      if (!rcv) begin
        linked = prev_loss_seen && (t - prev_loss_pos - 1 < g);
        if (linked) begin
          if (!run_open) begin
            run_open = 1;
            run_first = prev_loss_pos;
            lost_before_run = lost_before_prev;
            if (burst_cnt == 0 && prev_loss_pos == 0) burst_at_origin = 1;
          end
          run_last = t;
          lost_thru_run = lost_cnt + 1;
        end else if (run_open) begin
          close_run();
        end
        prev_loss_pos = t;
        lost_before_prev = lost_cnt;
        prev_loss_seen = 1;
        lost_cnt++;
      end
    end
    if (!last) return 0;

    n = pos_cnt;
    last_idx = (n != 0) ? n - 1 : 0;
    ends_bad = 0;
    mask = '0;
    if (run_open) begin
      // a burst too close to the trace end runs out to the end
      if (last_idx - run_last < g) begin
        run_last = last_idx;
        lost_thru_run = lost_cnt;
      end
      ends_bad = (run_last == last_idx);
      close_run();
    end
    gb = burst_cnt - ((burst_cnt != 0 && burst_at_origin) ? 1 : 0);
    bg = burst_cnt - ((burst_cnt != 0 && ends_bad) ? 1 : 0);
    good_len = n - bad_len_sum;
    good_lost = lost_cnt - bad_lost_total;
    // good length for p is one short when the trace ends good
    p_den = good_len - ((!ends_bad && good_len != 0) ? 1 : 0);
    est.good_to_bad_prob  = q16_frac(gb, p_den, UNDEF_P, mask);
    est.bad_to_good_prob  = q16_frac(bg, bad_len_sum, UNDEF_R, mask);
    est.good_receive_prob = q16_frac(good_len - good_lost, good_len, UNDEF_K, mask);
    est.bad_receive_prob  = q16_frac(bad_len_sum - bad_lost_total, bad_len_sum, UNDEF_H, mask);
    est.undefined_mask    = mask;
    est.burst_total       = burst_cnt[31:0];
    est.trace_length      = n[31:0];
    est.count_overflow    = cnt_saturated || (n > COUNT_FULL) || (burst_cnt > COUNT_FULL);
    clear_trace();
    return 1;
  endfunction

  // ---------------------------------------------------------------------------
  // Result side: random backpressure and field-by-field compare.
  // ---------------------------------------------------------------------------
  initial begin
    int stall;
    forever begin
      stall = calm ? 0 : $urandom_range(0, 14);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!(rst_n && out_ch.valid));
    end
  end

  function automatic void check_field(string name, longint unsigned want,
                                      longint unsigned got);
    if (want != got) begin
      mismatches++;
      if (mismatches <= 10)
        $display("MISMATCH %s: expected %0d, got %0d", name, want, got);
    end
  endfunction

  always @(posedge clk) begin
    result_t want, got;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got = out_ch.data;
      if (results_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("MISMATCH: unexpected result beat %p", got);
      end else begin
        want = results_due.pop_front();
        check_field("good_to_bad_prob", want.good_to_bad_prob, got.good_to_bad_prob);
        check_field("bad_to_good_prob", want.bad_to_good_prob, got.bad_to_good_prob);
        check_field("good_receive_prob", want.good_receive_prob, got.good_receive_prob);
        check_field("bad_receive_prob", want.bad_receive_prob, got.bad_receive_prob);
        check_field("undefined_mask", want.undefined_mask, got.undefined_mask);
        check_field("burst_total", want.burst_total, got.burst_total);
        check_field("trace_length", want.trace_length, got.trace_length);
        check_field("count_overflow", want.count_overflow, got.count_overflow);
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("loss_burst_model_estimator verification failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Sample side
  // ---------------------------------------------------------------------------
  // Send one sample beat; a typed row replaces the predicted result with want.
  task automatic send_sample(bit rcv, bit last, bit typed, result_t want);
    int idle;
    result_t est;
    idle = calm ? 0 : $urandom_range(0, 14);
    if (idle > 0) begin
      in_ch.valid <= 1'b0;
      repeat (idle) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data.sample_received <= rcv;
    in_ch.data.last_sample <= last;
    do @(posedge clk); while (!in_ch.ready);
    if (burst_model_step(rcv, last, est))
      results_due = {results_due, (typed ? want : est)};
  endtask

  // Hold off until every trace result is back, then give the divider time to settle.
  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    while (results_due.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
  endtask

  task automatic write_gap(logic [7:0] value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    gap_reg = value;
    cfg_we <= 1'b0;
  endtask

  // Random trace: a two-state loss process, or plain noise now and then.
  task automatic send_trace(output int sent);
    int len, p_enter, p_leave, p_bad_loss, p_good_loss;
    bit bad_state, rcv;
    len = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 150) : $urandom_range(1, 30);
    p_enter = $urandom_range(2, 35);
    p_leave = $urandom_range(10, 60);
    p_bad_loss = $urandom_range(50, 100);
    p_good_loss = $urandom_range(0, 8);
    bad_state = $urandom_range(0, 1);
    if ($urandom_range(0, 9) == 0) begin
      p_bad_loss = 50;
      p_good_loss = 50;
    end
    for (int i = 0; i < len; i++) begin
      if (bad_state) bad_state = ($urandom_range(0, 99) >= p_leave);
      else           bad_state = ($urandom_range(0, 99) < p_enter);
      rcv = bad_state ? ($urandom_range(0, 99) >= p_bad_loss)
                      : ($urandom_range(0, 99) >= p_good_loss);
      send_sample(rcv, i == len - 1, 1'b0, '0);
    end
    sent = len;
  endtask

  typedef struct {
    bit      rcv;
    bit      last;
    bit      typed;
    result_t want;
  } stim_row_t;

  // Directed rows at the reset gap of 16.
  stim_row_t directed[] = '{
    // lone received sample: p has no good length left, no bad state at all
    '{1'b1, 1'b1, 1'b1, '{16'd0, 16'd0, 16'hFFFF, 16'd0, UNDEF_P | UNDEF_R | UNDEF_H,
                          32'd0, 32'd1, 1'b0}},
    // lone lost sample: no burst, k is zero
    '{1'b0, 1'b1, 1'b1, '{16'd0, 16'd0, 16'd0, 16'd0, UNDEF_P | UNDEF_R | UNDEF_H,
                          32'd0, 32'd1, 1'b0}},
    // two losses from the origin: whole trace is one burst
    '{1'b0, 1'b0, 1'b0, '0},
    '{1'b0, 1'b1, 1'b1, '{16'd0, 16'd0, 16'd0, 16'd0, UNDEF_P | UNDEF_K,
                          32'd1, 32'd2, 1'b0}},
    // burst near the end gets stretched to the trace end
    '{1'b1, 1'b0, 1'b0, '0},
    '{1'b0, 1'b0, 1'b0, '0},
    '{1'b1, 1'b0, 1'b0, '0},
    '{1'b0, 1'b0, 1'b0, '0},
    '{1'b1, 1'b0, 1'b0, '0},
    '{1'b1, 1'b1, 1'b0, '0},
    // isolated losses only, trace ends good
    '{1'b0, 1'b0, 1'b0, '0},
    '{1'b1, 1'b0, 1'b0, '0},
    '{1'b1, 1'b0, 1'b0, '0},
    '{1'b1, 1'b1, 1'b0, '0},
    // all received
    '{1'b1, 1'b0, 1'b0, '0},
    '{1'b1, 1'b0, 1'b0, '0},
    '{1'b1, 1'b1, 1'b0, '0},
    // burst from origin that spans a received sample and runs to the end
    '{1'b0, 1'b0, 1'b0, '0},
    '{1'b0, 1'b0, 1'b0, '0},
    '{1'b1, 1'b0, 1'b0, '0},
    '{1'b0, 1'b0, 1'b0, '0},
    '{1'b0, 1'b1, 1'b0, '0}
  };

  // gap settings per phase (the last phase draws a random gap); 0 means the default, 1 and 255 are the extremes
  logic [7:0] phase_gaps[] = '{8'd16, 8'd0, 8'd1, 8'd255, 8'd2, 8'd5, 8'd9};

  initial begin
    int sent, budget;
    in_ch.valid <= 1'b0;
    in_ch.data <= '0;
    gap_reg = GAP_DEFAULT;
    clear_trace();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed[i])
      send_sample(directed[i].rcv, directed[i].last, directed[i].typed, directed[i].want);

    foreach (phase_gaps[p]) begin
      wait_idle();
      write_gap((p == phase_gaps.size() - 1) ? 8'($urandom_range(0, 255)) : phase_gaps[p]);
      calm = (p == 2);
      budget = 0;
      while (budget < 75) begin
        send_trace(sent);
        budget += sent;
      end
    end
    calm = 1'b0;

    in_ch.valid <= 1'b0;
    while (results_due.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
    if (mismatches == 0)
      $display("loss_burst_model_estimator verification clean");
    else
      $display("loss_burst_model_estimator verification failed");
    $finish;
  end

endmodule

@@ filelist.f @@
design/lbme_pkg.sv
design/lbme_if.sv
design/lbme_ctrl.sv
design/lbme_dp.sv
design/loss_burst_model_estimator.sv
design/lbme_checker.sv
tb/tb_loss_burst_model_estimator.sv
